FILE: design/pfr_pkg.sv
// ----------------------------------------------------------------------------
// pfr_pkg: shared types and constants of the page frame replacement core
// Holds the controller state type, the command and status bundles between
// the controller and the datapath, and the register map.
// ----------------------------------------------------------------------------
package pfr_pkg;

    // Register map and port widths
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int SLOT_W    = 3;
    localparam int CNT_W     = 32;

    localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_POLICY        = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = CFG_W'(3);

    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;
    localparam logic POLICY_RST  = POLICY_LRU;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_SCAN,
        ST_SCAN_END,
        ST_DECIDE,
        ST_TOUCH,
        ST_TOUCH_END,
        ST_COMMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;      // latch the reference and restart the frame index
        logic mod_step;  // subtract the active count from the FIFO slot
        logic rd_scan;   // read frame at the index for the lookup pass
        logic rd_touch;  // read frame at the index for the recency pass
        logic decide;    // pick the slot and restart the frame index
        logic commit;    // write the page, counters and the result
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic ptr_ge_n;  // FIFO slot still at or above the active count
        logic idx_last;  // frame index at the last active frame
    } t_stat;

endpackage

FILE: design/pfr_ctrl.sv
// ----------------------------------------------------------------------------
// pfr_ctrl: sequencer of the page frame replacement core
// Steps one reference through the FIFO slot reduction, the lookup pass over
// the active frames, the slot choice, the recency pass and the commit.
// ----------------------------------------------------------------------------
module pfr_ctrl
    import pfr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MOD;
                end
            end
            ST_MOD: begin
                if (i_stat.ptr_ge_n) begin
                    o_cmd.mod_step = 1'b1;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.rd_scan = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = ST_TOUCH;
            end
            ST_TOUCH: begin
                o_cmd.rd_touch = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = ST_TOUCH_END;
                end
            end
            ST_TOUCH_END: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Every pass ends in a commit and a return to idle
    a_commit_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> !o_busy)
        else $error("commit not followed by idle");

    // A reference is only loaded when idle
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (r_state == ST_IDLE))
        else $error("load outside idle");

    // Lookup and recency reads never overlap
    a_rd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.rd_scan && o_cmd.rd_touch))
        else $error("overlapping frame reads");

endmodule

FILE: design/pfr_dpath.sv
// ----------------------------------------------------------------------------
// pfr_dpath: frame table datapath of the page frame replacement core
// Holds the page and rank memories, the valid bits, the FIFO pointer, the
// lookup results, the saturating counters and the result registers.
// ----------------------------------------------------------------------------
module pfr_dpath
    import pfr_pkg::*;
#(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic [PAGE_BITS-1:0] i_page_number,
    input  logic [CFG_W-1:0]     i_frames_in_use,
    input  logic                 i_policy,
    output logic                 o_done,
    output logic                 o_hit,
    output logic [SLOT_W-1:0]    o_slot,
    output logic                 o_evicted_valid,
    output logic [PAGE_BITS-1:0] o_evicted_page,
    output logic [CNT_W-1:0]     o_hit_count,
    output logic [CNT_W-1:0]     o_fault_count
);

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int OLD_W = IDX_W + 1;
    localparam int N_W   = ((OLD_W > CFG_W) ? OLD_W : CFG_W) + 1;

    localparam logic [N_W-1:0]   FRAMES_N  = N_W'(FRAMES);
    localparam logic [OLD_W-1:0] OLD_EMPTY = OLD_W'(FRAMES);
    localparam logic [IDX_W-1:0] RANK_TOP  = IDX_W'(FRAMES - 1);

    // Memories
    logic [PAGE_BITS-1:0] page_mem [FRAMES];
    logic [IDX_W-1:0]     rank_mem [FRAMES];

    // Control state
    logic [FRAMES-1:0]    r_valid;
    logic [IDX_W-1:0]     r_fifo_ptr;
    logic [CNT_W-1:0]     r_hits;
    logic [CNT_W-1:0]     r_faults;
    logic                 r_done;
    logic                 r_rd_vld;
    logic                 r_rd_touch;

    // Per-reference working registers
    logic [PAGE_BITS-1:0] r_page;
    logic [N_W-1:0]       r_n;
    logic                 r_policy;
    logic [IDX_W-1:0]     r_fslot;
    logic [IDX_W-1:0]     r_idx;
    logic [IDX_W-1:0]     r_rd_idx;
    logic [PAGE_BITS-1:0] r_pg_q;
    logic [IDX_W-1:0]     r_rk_q;

    // Lookup results
    logic                 r_hit;
    logic [IDX_W-1:0]     r_hslot;
    logic [IDX_W-1:0]     r_hrank;
    logic                 r_inv_found;
    logic [IDX_W-1:0]     r_inv_slot;
    logic [IDX_W-1:0]     r_best_slot;
    logic [IDX_W-1:0]     r_best_rank;
    logic [PAGE_BITS-1:0] r_best_page;
    logic                 r_f_valid;
    logic [IDX_W-1:0]     r_f_rank;
    logic [PAGE_BITS-1:0] r_f_page;

    // Chosen slot
    logic [IDX_W-1:0]     r_slot;
    logic [OLD_W-1:0]     r_old;
    logic                 r_ev_valid;
    logic [PAGE_BITS-1:0] r_ev_page;

    // Result registers
    logic                 r_out_hit;
    logic [SLOT_W-1:0]    r_out_slot;
    logic                 r_out_ev_valid;
    logic [PAGE_BITS-1:0] r_out_ev_page;

    logic [N_W-1:0]       w_n;
    logic                 w_rd;
    logic                 w_scan_eval;
    logic                 w_touch_eval;
    logic                 w_eval_v;
    logic                 w_rk_we;
    logic [IDX_W-1:0]     w_rk_wdata;
    logic [N_W-1:0]       w_slot_next;

    // Clamp the active frame count to one through FRAMES
    always_comb begin
        if (i_frames_in_use == '0) begin
            w_n = N_W'(1);
        end else if (N_W'(i_frames_in_use) > FRAMES_N) begin
            w_n = FRAMES_N;
        end else begin
            w_n = N_W'(i_frames_in_use);
        end
    end

    assign o_stat.ptr_ge_n = (N_W'(r_fslot) >= r_n);
    assign o_stat.idx_last = (N_W'(r_idx) == (r_n - N_W'(1)));

    assign w_rd         = i_cmd.rd_scan || i_cmd.rd_touch;
    assign w_scan_eval  = r_rd_vld && !r_rd_touch;
    assign w_touch_eval = r_rd_vld && r_rd_touch;
    assign w_eval_v     = r_valid[r_rd_idx];

    // Age the frames younger than the touched one, make the touched one newest
    always_comb begin
        w_rk_we    = 1'b0;
        w_rk_wdata = r_rk_q + IDX_W'(1);
        if (w_touch_eval) begin
            if (r_rd_idx == r_slot) begin
                w_rk_we    = 1'b1;
                w_rk_wdata = '0;
            end else if (w_eval_v && (OLD_W'(r_rk_q) < r_old) && (r_rk_q < RANK_TOP)) begin
                w_rk_we = 1'b1;
            end
        end
    end

    assign w_slot_next = N_W'(r_slot) + N_W'(1);

    // Page and rank memories
    always_ff @(posedge i_clk) begin
        if (w_rd) begin
            r_pg_q <= page_mem[r_idx];
            r_rk_q <= rank_mem[r_idx];
        end
        if (w_rk_we) begin
            rank_mem[r_rd_idx] <= w_rk_wdata;
        end
        if (i_cmd.commit) begin
            page_mem[r_slot] <= r_page;
        end
    end

    // Control state: valid bits, pointer, counters, read tracking, strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_fifo_ptr <= '0;
            r_hits     <= '0;
            r_faults   <= '0;
            r_done     <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_rd_touch <= 1'b0;
        end else begin
            r_done     <= i_cmd.commit;
            r_rd_vld   <= w_rd;
            r_rd_touch <= i_cmd.rd_touch;
            if (i_cmd.commit) begin
                r_valid[r_slot] <= 1'b1;
                if (r_hit) begin
                    if (r_hits != '1) begin
                        r_hits <= r_hits + CNT_W'(1);
                    end
                end else begin
                    if (r_faults != '1) begin
                        r_faults <= r_faults + CNT_W'(1);
                    end
                    if (r_policy == POLICY_FIFO) begin
                        r_fifo_ptr <= (w_slot_next == r_n) ? '0 : IDX_W'(w_slot_next);
                    end
                end
            end
        end
    end

    // Working registers: load, FIFO slot reduction, lookup, slot choice
    always_ff @(posedge i_clk) begin
        // Latch the reference
        if (i_cmd.load) begin
            r_page      <= i_page_number;
            r_n         <= w_n;
            r_policy    <= i_policy;
            r_fslot     <= r_fifo_ptr;
            r_idx       <= '0;
            r_hit       <= 1'b0;
            r_inv_found <= 1'b0;
            r_best_slot <= '0;
            r_best_rank <= '0;
            r_f_valid   <= 1'b0;
        end

        // Reduce the FIFO pointer below the active count
        if (i_cmd.mod_step) begin
            r_fslot <= IDX_W'(N_W'(r_fslot) - r_n);
        end

        // Advance the frame index
        if (w_rd) begin
            r_idx    <= r_idx + IDX_W'(1);
            r_rd_idx <= r_idx;
        end

        // Lookup: first match, first empty, oldest, FIFO candidate
        if (w_scan_eval) begin
            if (w_eval_v && (r_pg_q == r_page) && !r_hit) begin
                r_hit   <= 1'b1;
                r_hslot <= r_rd_idx;
                r_hrank <= r_rk_q;
            end
            if (!w_eval_v && !r_inv_found) begin
                r_inv_found <= 1'b1;
                r_inv_slot  <= r_rd_idx;
            end
            if ((r_rd_idx == '0) || (r_rk_q > r_best_rank)) begin
                r_best_slot <= r_rd_idx;
                r_best_rank <= r_rk_q;
                r_best_page <= r_pg_q;
            end
            if (r_rd_idx == r_fslot) begin
                r_f_valid <= w_eval_v;
                r_f_rank  <= r_rk_q;
                r_f_page  <= r_pg_q;
            end
        end

        // Pick the slot and the rank it leaves
        if (i_cmd.decide) begin
            r_idx <= '0;
            priority if (r_hit) begin
                r_slot     <= r_hslot;
                r_old      <= OLD_W'(r_hrank);
                r_ev_valid <= 1'b0;
                r_ev_page  <= '0;
            end else if (r_policy == POLICY_FIFO) begin
                r_slot     <= r_fslot;
                r_old      <= r_f_valid ? OLD_W'(r_f_rank) : OLD_EMPTY;
                r_ev_valid <= r_f_valid;
                r_ev_page  <= r_f_valid ? r_f_page : '0;
            end else if (r_inv_found) begin
                r_slot     <= r_inv_slot;
                r_old      <= OLD_EMPTY;
                r_ev_valid <= 1'b0;
                r_ev_page  <= '0;
            end else begin
                r_slot     <= r_best_slot;
                r_old      <= OLD_W'(r_best_rank);
                r_ev_valid <= 1'b1;
                r_ev_page  <= r_best_page;
            end
        end

        // Hold the result for the strobe
        if (i_cmd.commit) begin
            r_out_hit      <= r_hit;
            r_out_slot     <= SLOT_W'(r_slot);
            r_out_ev_valid <= r_ev_valid;
            r_out_ev_page  <= r_ev_page;
        end
    end

    assign o_done          = r_done;
    assign o_hit           = r_out_hit;
    assign o_slot          = r_out_slot;
    assign o_evicted_valid = r_out_ev_valid;
    assign o_evicted_page  = r_out_ev_page;
    assign o_hit_count     = r_hits;
    assign o_fault_count   = r_faults;

    // The result strobe follows a commit
    a_done_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_cmd.commit))
        else $error("result strobe without commit");

    // The chosen slot lies among the active frames
    a_slot_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (N_W'(r_slot) < r_n))
        else $error("slot outside active frames");

    // A hit never displaces a page
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_hit) |-> !o_evicted_valid)
        else $error("eviction reported on a hit");

    // Committed frame is valid afterwards
    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_valid[$past(r_slot)])
        else $error("committed frame not valid");

endmodule

FILE: design/page_frame_replacement_core.sv
// ----------------------------------------------------------------------------
// page_frame_replacement_core: FIFO / LRU page frame replacement table
// Fully associative frame table. Each reference reports hit or fault, the
// frame used, any displaced page and saturating hit and fault counts.
//
//   channel   handshake              payload
//   --------  ---------------------  ------------------------------------------
//   request   i_start, o_busy        i_page_number
//   result    o_done (one cycle)     o_hit, o_slot, o_evicted_valid,
//                                    o_evicted_page, o_hit_count, o_fault_count
//   config    i_cfg_we               i_cfg_idx, i_cfg_wdata
//
// A reference is transferred when i_start is high and o_busy is low. It goes
// through two passes over the frame memories (lookup, then recency update),
// each over the n active frames, n the active frame count; a FIFO pointer
// left above a lowered frame count is first reduced by repeated subtraction
// of n. o_busy falls in the cycle that shows the result, so the next
// reference may be transferred at once. Reset is synchronous, active low, and
// empties every frame. The receiver takes every result as shown.
// ----------------------------------------------------------------------------
module page_frame_replacement_core
    import pfr_pkg::*;
#(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [PAGE_BITS-1:0] i_page_number,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    output logic                 o_done,
    output logic                 o_hit,
    output logic [SLOT_W-1:0]    o_slot,
    output logic                 o_evicted_valid,
    output logic [PAGE_BITS-1:0] o_evicted_page,
    output logic [CNT_W-1:0]     o_hit_count,
    output logic [CNT_W-1:0]     o_fault_count
);

    logic [CFG_W-1:0] r_frames_in_use;
    logic             r_policy;
    t_cmd             w_cmd;
    t_stat            w_stat;

    // Configuration registers; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= FRAMES_IN_USE_RST;
            r_policy        <= POLICY_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_FRAMES_IN_USE) begin
                r_frames_in_use <= i_cfg_wdata;
            end else if (i_cfg_idx == REG_POLICY) begin
                r_policy <= i_cfg_wdata[0];
            end
        end
    end

    pfr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (o_busy)
    );

    pfr_dpath #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_page_number   (i_page_number),
        .i_frames_in_use (r_frames_in_use),
        .i_policy        (r_policy),
        .o_done          (o_done),
        .o_hit           (o_hit),
        .o_slot          (o_slot),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_hit_count     (o_hit_count),
        .o_fault_count   (o_fault_count)
    );

endmodule

FILE: verif/pfr_outcome_checker.sv
// ----------------------------------------------------------------------------
// pfr_outcome_checker: result checker for the page frame replacement core
// Watches the request, config and result channels, keeps its own copy of the
// frame table, recency ranks, FIFO pointer and counters, and predicts each
// outcome when a request is transferred. Every result strobe is compared
// field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module pfr_outcome_checker
    import pfr_pkg::*;
#(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  logic [PAGE_BITS-1:0] i_page_number,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 i_done,
    input  logic                 i_hit,
    input  logic [SLOT_W-1:0]    i_slot,
    input  logic                 i_evicted_valid,
    input  logic [PAGE_BITS-1:0] i_evicted_page,
    input  logic [CNT_W-1:0]     i_hit_count,
    input  logic [CNT_W-1:0]     i_fault_count,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked
);

    typedef struct packed {
        logic                 hit;
        logic [SLOT_W-1:0]    slot;
        logic                 ev_valid;
        logic [PAGE_BITS-1:0] ev_page;
        logic [CNT_W-1:0]     hits;
        logic [CNT_W-1:0]     faults;
    } t_outcome;

    // Shadow frame table and registers
    logic [PAGE_BITS-1:0] frame_page  [FRAMES];
    logic                 frame_valid [FRAMES];
    int unsigned          use_age     [FRAMES];
    int unsigned          fifo_ptr;
    logic [CNT_W-1:0]     hit_total;
    logic [CNT_W-1:0]     fault_total;
    logic [CFG_W-1:0]     cfg_frames;
    logic                 cfg_policy;

    t_outcome pending_outcomes [$];

    // Clamp the programmed frame count to 1..FRAMES
    function automatic int unsigned active_count();
        int unsigned n;
        n = cfg_frames;
        if (n == 0) n = 1;
        if (n > FRAMES) n = FRAMES;
        return n;
    endfunction

    task automatic clear_table();
        int unsigned i;
        for (i = 0; i < FRAMES; i++) begin
            frame_page[i]  = '0;
            frame_valid[i] = 1'b0;
            use_age[i]     = 0;
        end
        fifo_ptr    = 0;
        hit_total   = '0;
        fault_total = '0;
        cfg_frames  = FRAMES_IN_USE_RST;
        cfg_policy  = POLICY_RST;
    endtask

    // Make frame s the youngest; age every valid frame younger than it was
    task automatic promote_frame(input int unsigned s, input int unsigned n,
                                 input logic was_valid);
        int unsigned i;
        int unsigned limit;
        limit = was_valid ? use_age[s] : FRAMES;
        for (i = 0; i < n; i++) begin
            if (i != s && frame_valid[i] && use_age[i] < limit
                && use_age[i] < FRAMES - 1)
                use_age[i]++;
        end
        use_age[s] = 0;
    endtask

    // Look the page up, replace on a fault, and build the outcome
    task automatic lookup_and_replace(input logic [PAGE_BITS-1:0] page,
                                      output t_outcome res);
        int unsigned i;
        int unsigned n;
        int unsigned slot;
        int unsigned oldest;
        logic        found;
        n     = active_count();
        res   = '0;
        found = 1'b0;
        slot  = 0;
        for (i = 0; i < n; i++) begin
            if (!found && frame_valid[i] && frame_page[i] == page) begin
                found = 1'b1;
                slot  = i;
            end
        end
        if (found) begin
            res.hit = 1'b1;
            if (hit_total != '1) hit_total++;
            promote_frame(slot, n, 1'b1);
        end else begin
            if (cfg_policy == POLICY_FIFO) begin
                slot     = fifo_ptr % n;
                fifo_ptr = (slot + 1 == n) ? 0 : slot + 1;
            end else begin
                // first empty frame, else the oldest with lowest index on ties
                for (i = 0; i < n; i++) begin
                    if (!found && !frame_valid[i]) begin
                        found = 1'b1;
                        slot  = i;
                    end
                end
                if (!found) begin
                    oldest = 0;
                    slot   = 0;
                    for (i = 0; i < n; i++) begin
                        if (use_age[i] > oldest) begin
                            oldest = use_age[i];
                            slot   = i;
                        end
                    end
                end
            end
            res.ev_valid = frame_valid[slot];
            res.ev_page  = frame_valid[slot] ? frame_page[slot] : '0;
            promote_frame(slot, n, frame_valid[slot]);
            frame_page[slot]  = page;
            frame_valid[slot] = 1'b1;
            if (fault_total != '1) fault_total++;
        end
        res.slot   = SLOT_W'(slot);
        res.hits   = hit_total;
        res.faults = fault_total;
    endtask

    task automatic compare_field(input string field, input logic [CNT_W-1:0] want,
                                 input logic [CNT_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            o_fail_count++;
        end
    endtask

    // Sample all channels at the rising edge
    always @(posedge i_clk) begin : monitor
        t_outcome want;
        if (!i_rst_n) begin
            clear_table();
            pending_outcomes.delete();
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            // Retire the oldest prediction on a result strobe
            if (i_done === 1'b1) begin
                if (pending_outcomes.size() == 0) begin
                    $display("%0t: result strobe with no reference outstanding", $time);
                    o_fail_count++;
                end else begin
                    want = pending_outcomes.pop_front();
                    compare_field("hit", CNT_W'(want.hit), CNT_W'(i_hit));
                    compare_field("slot", CNT_W'(want.slot), CNT_W'(i_slot));
                    compare_field("evicted_valid", CNT_W'(want.ev_valid),
                                  CNT_W'(i_evicted_valid));
                    compare_field("evicted_page", CNT_W'(want.ev_page),
                                  CNT_W'(i_evicted_page));
                    compare_field("hit_count", want.hits, i_hit_count);
                    compare_field("fault_count", want.faults, i_fault_count);
                    o_checked++;
                end
            end
            // Track register writes; spare indexes are dropped
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FRAMES_IN_USE: cfg_frames = i_cfg_wdata;
                    REG_POLICY:        cfg_policy = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            // Predict on every request transfer
            if (i_start && !i_busy) begin
                lookup_and_replace(i_page_number, want);
                pending_outcomes.push_back(want);
            end
        end
        o_pending = pending_outcomes.size();
    end

endmodule

FILE: verif/tb_page_frame_replacement_core.sv
// ----------------------------------------------------------------------------
// tb_page_frame_replacement_core: testbench of the page frame replacement core
// Drives a short directed run over the corner cases of both policies, then
// phases of random page references with locality under random register
// settings, written while the core is idle. A separate checker predicts and
// compares every result; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_page_frame_replacement_core;
    import pfr_pkg::*;

    localparam int FRAMES      = 8;
    localparam int PAGE_BITS   = 16;
    localparam int IDLE_LIMIT  = 2000;
    localparam int RANDOM_REFS = 1350;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_start;
    logic                 o_busy;
    logic [PAGE_BITS-1:0] i_page_number;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_wdata;
    logic                 o_done;
    logic                 o_hit;
    logic [SLOT_W-1:0]    o_slot;
    logic                 o_evicted_valid;
    logic [PAGE_BITS-1:0] o_evicted_page;
    logic [CNT_W-1:0]     o_hit_count;
    logic [CNT_W-1:0]     o_fault_count;

    int fail_count;
    int pending;
    int checked;
    int refs_sent;
    int settings_made;
    int idle_cycles;
    bit gaps_on;

    logic [PAGE_BITS-1:0] hot_base;
    int                   hot_span;

    // Clock, period 2
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    page_frame_replacement_core #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_page_number   (i_page_number),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_done          (o_done),
        .o_hit           (o_hit),
        .o_slot          (o_slot),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_hit_count     (o_hit_count),
        .o_fault_count   (o_fault_count)
    );

    pfr_outcome_checker #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .i_busy          (o_busy),
        .i_page_number   (i_page_number),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_done          (o_done),
        .i_hit           (o_hit),
        .i_slot          (o_slot),
        .i_evicted_valid (o_evicted_valid),
        .i_evicted_page  (o_evicted_page),
        .i_hit_count     (o_hit_count),
        .i_fault_count   (o_fault_count),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    // Watchdog: end the run after too many cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_start && !o_busy) || o_done || i_cfg_we) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("FAIL page_frame_replacement_core");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Hold off requests until every outstanding result has come back
    task automatic drain();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending != 0 || o_busy) @(negedge i_clk);
    endtask

    task automatic apply_setting(input logic [CFG_W-1:0] frames, input logic pol);
        logic [CFG_W-1:0] pol_word;
        pol_word    = CFG_W'($urandom);
        pol_word[0] = pol;
        drain();
        write_reg(REG_FRAMES_IN_USE, frames);
        write_reg(REG_POLICY, pol_word);
        settings_made++;
    endtask

    // Present one reference; idle at random in cycles the core could take it
    task automatic send_ref(input logic [PAGE_BITS-1:0] page);
        @(negedge i_clk);
        while (o_busy || (gaps_on && $urandom_range(0, 99) < 38)) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        i_start       <= 1'b1;
        i_page_number <= page;
        @(posedge i_clk);
        refs_sent++;
    endtask

    // Mostly a small hot set for hits, some near misses, some fully random
    function automatic logic [PAGE_BITS-1:0] pick_page();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return hot_base + PAGE_BITS'($urandom_range(0, hot_span - 1));
        if (r < 90) return hot_base ^ PAGE_BITS'($urandom_range(0, 63));
        return PAGE_BITS'($urandom);
    endfunction

    initial begin : stimulus
        int               phase;
        int               len;
        int               k;
        int               random_sent;
        int               eff;
        logic [CFG_W-1:0] frames;
        logic             pol;

        i_rst_n       = 1'b0;
        i_start       = 1'b0;
        i_page_number = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_wdata   = '0;
        refs_sent     = 0;
        settings_made = 0;
        gaps_on       = 1'b1;
        hot_base      = '0;
        hot_span      = 1;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset setting, LRU over three frames: empty frames, hits, LRU victim
        send_ref(16'h0000);
        send_ref(16'h0000);
        send_ref(16'hFFFF);
        send_ref(16'h8000);
        send_ref(16'h0001);
        send_ref(16'h0000);
        send_ref(16'h1234);

        // FIFO over all frames: overwrite while other frames are still empty
        apply_setting(CFG_W'(8), POLICY_FIFO);
        write_reg(REG_SPARE_2, 4'hF);
        write_reg(REG_SPARE_3, 4'hA);
        send_ref(16'h0101);
        send_ref(16'h0202);
        send_ref(16'h0303);
        send_ref(16'h0404);
        send_ref(16'h0505);

        // Lower the count below the FIFO pointer
        apply_setting(CFG_W'(2), POLICY_FIFO);
        send_ref(16'h0606);
        send_ref(16'h0101);

        // A count of zero acts as one frame
        apply_setting(CFG_W'(0), POLICY_FIFO);
        send_ref(16'h0707);
        send_ref(16'h0707);

        // Count above the table acts as all frames; parked frames kept their pages
        apply_setting(CFG_W'(15), POLICY_LRU);
        send_ref(16'h0404);
        send_ref(16'h0505);
        send_ref(16'hFFFF);
        send_ref(16'h9999);

        // Random phases under random settings
        phase       = 0;
        random_sent = 0;
        while (random_sent < RANDOM_REFS) begin
            case ($urandom_range(0, 9))
                0:       frames = CFG_W'(0);
                1:       frames = CFG_W'(1);
                2:       frames = CFG_W'(8);
                3:       frames = CFG_W'(15);
                default: frames = CFG_W'($urandom_range(0, 15));
            endcase
            pol = 1'($urandom_range(0, 1));
            apply_setting(frames, pol);
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                          CFG_W'($urandom));
            eff = (frames == '0) ? 1 : (int'(frames) > FRAMES) ? FRAMES : int'(frames);
            hot_base = PAGE_BITS'($urandom);
            hot_span = eff + int'($urandom_range(0, 3));
            gaps_on  = (phase != 3);
            len      = $urandom_range(40, 120);
            for (k = 0; k < len && random_sent < RANDOM_REFS; k++) begin
                if ($urandom_range(0, 49) == 0) drain();
                send_ref(pick_page());
                random_sent++;
            end
            phase++;
        end

        // Wait out the last results and a little more
        drain();
        repeat (40) @(posedge i_clk);

        $display("Sent %0d page references, %0d results checked, %0d register settings.",
                 refs_sent, checked, settings_made);
        $display("Both policies, frame counts 0 to 15, pointer past a lowered count, spare regs.");
        if (fail_count == 0 && pending == 0) begin
            $display("PASS page_frame_replacement_core");
        end else begin
            $display("FAIL page_frame_replacement_core");
        end
        $finish;
    end

endmodule
